// ===== rtl/kdfd_pkg.sv =====
`timescale 1ns / 1ps

package kdfd_pkg;

  localparam int CfgIndexWidth = 2;

  localparam logic [CfgIndexWidth-1:0] CFG_CONTROL_PREFIX = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CFG_HIGHBIT_PREFIX = 2'd1;
  localparam logic [CfgIndexWidth-1:0] CFG_REPEAT_PREFIX  = 2'd2;

  localparam logic [7:0] ControlPrefixReset = 8'd35;
  localparam logic [7:0] HighbitPrefixReset = 8'd38;
  localparam logic [7:0] RepeatPrefixReset  = 8'd126;

  localparam logic [7:0] CountBias = 8'd32;
  localparam logic [7:0] QuoteFlip = 8'h40;
  localparam logic [7:0] HighBit   = 8'h80;

  typedef enum logic [2:0] {
    PH_START,
    PH_COUNT,
    PH_AFTER_CNT,
    PH_AFTER_HIGH,
    PH_QUOTED
  } phase_t;

  typedef struct packed {
    logic [7:0] control_prefix;
    logic [7:0] highbit_prefix;
    logic [7:0] repeat_prefix;
  } prefix_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] repeat_count;
    logic       truncated;
    logic       field_end;
  } result_t;

endpackage

// ===== rtl/kermit_data_field_decoder_top.sv =====
`timescale 1ns / 1ps

// Kermit data field decoder. Raw field bytes enter one per beat with a flag on the
// field's last byte; each decoded character with a nonzero repeat count leaves as
// one beat carrying the byte and its repeat count (the run is not expanded here),
// and a field that ends inside an unfinished prefix sequence gives one beat flagged
// as truncated. A byte passes through the input register, then through the prefix
// decode into the output register. One byte is accepted per cycle sustained; the
// rate is set by the phase update, and stalls only when the output register holds
// a beat that is not taken and the byte in decode produces a beat. Prefix registers may
// be written only while no bytes are in flight.

module kermit_data_field_decoder_top
  import kdfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0]               cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_last_in_field,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               out_byte,
  output logic [7:0]               out_repeat_count,
  output logic                     out_truncated,
  output logic                     out_field_end
);

  prefix_cfg_t prefixes;

  logic       hold_valid_r;
  logic [7:0] hold_byte_r;
  logic       hold_last_r;

  logic    out_valid_r;
  result_t out_res_r;

  logic    has_result;
  result_t result;
  logic    out_free;
  logic    step;

  kdfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .prefixes  (prefixes)
  );

  kdfd_decode u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .prefixes   (prefixes),
    .raw_byte   (hold_byte_r),
    .raw_last   (hold_last_r),
    .step       (step),
    .has_result (has_result),
    .result     (result)
  );

  assign out_free = !out_valid_r || out_ready;
  assign step     = hold_valid_r && (out_free || !has_result);
  assign in_ready = !hold_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte_r <= in_byte;
      hold_last_r <= in_last_in_field;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && step && has_result) begin
      out_res_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_res_r.out_byte;
  assign out_repeat_count = out_res_r.repeat_count;
  assign out_truncated    = out_res_r.truncated;
  assign out_field_end    = out_res_r.field_end;

endmodule

// ===== rtl/kdfd_cfg_regs.sv =====
`timescale 1ns / 1ps

module kdfd_cfg_regs
  import kdfd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [7:0]               cfg_wdata,
  output prefix_cfg_t              prefixes
);

  prefix_cfg_t prefixes_r;
  prefix_cfg_t prefixes_nxt;

  always_comb begin
    prefixes_nxt = prefixes_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CONTROL_PREFIX: prefixes_nxt.control_prefix = cfg_wdata;
        CFG_HIGHBIT_PREFIX: prefixes_nxt.highbit_prefix = cfg_wdata;
        CFG_REPEAT_PREFIX:  prefixes_nxt.repeat_prefix  = cfg_wdata;
        default:            prefixes_nxt = prefixes_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefixes_r.control_prefix <= ControlPrefixReset;
      prefixes_r.highbit_prefix <= HighbitPrefixReset;
      prefixes_r.repeat_prefix  <= RepeatPrefixReset;
    end else begin
      prefixes_r <= prefixes_nxt;
    end
  end

  assign prefixes = prefixes_r;

endmodule

// ===== rtl/kdfd_decode.sv =====
`timescale 1ns / 1ps

module kdfd_decode
  import kdfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  prefix_cfg_t prefixes,
  input  logic [7:0]  raw_byte,
  input  logic        raw_last,
  input  logic        step,
  output logic        has_result,
  output result_t     result
);

  phase_t     phase_r;
  phase_t     phase_nxt;
  logic       high_pending_r;
  logic       high_pending_nxt;
  logic [7:0] pending_count_r;
  logic [7:0] pending_count_nxt;

  logic       have_char;
  logic [7:0] ch;
  logic       is_prefix;

  assign is_prefix = (raw_byte == prefixes.control_prefix) ||
                     (raw_byte == prefixes.highbit_prefix) ||
                     (raw_byte == prefixes.repeat_prefix);

  always_comb begin
    phase_nxt         = phase_r;
    high_pending_nxt  = high_pending_r;
    pending_count_nxt = pending_count_r;
    have_char         = 1'b0;
    ch                = '0;
    has_result        = 1'b0;
    result            = '0;

    case (phase_r)
      PH_QUOTED: begin
        ch        = is_prefix ? raw_byte : (raw_byte ^ QuoteFlip);
        have_char = 1'b1;
      end
      PH_COUNT: begin
        pending_count_nxt = raw_byte - CountBias;
        phase_nxt         = PH_AFTER_CNT;
      end
      PH_START, PH_AFTER_CNT, PH_AFTER_HIGH: begin
        if (phase_r == PH_START && raw_byte == prefixes.repeat_prefix) begin
          phase_nxt = PH_COUNT;
        end else if (phase_r != PH_AFTER_HIGH && raw_byte == prefixes.highbit_prefix) begin
          high_pending_nxt = 1'b1;
          phase_nxt        = PH_AFTER_HIGH;
        end else if (raw_byte == prefixes.control_prefix) begin
          phase_nxt = PH_QUOTED;
        end else begin
          ch        = raw_byte;
          have_char = 1'b1;
        end
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase

    if (have_char) begin
      has_result          = (pending_count_r != 8'd0);
      result.out_byte     = high_pending_r ? (ch | HighBit) : ch;
      result.repeat_count = pending_count_r;
      result.truncated    = 1'b0;
      result.field_end    = raw_last;
    end else if (raw_last) begin
      has_result       = 1'b1;
      result.truncated = 1'b1;
      result.field_end = 1'b1;
    end

    if (have_char || raw_last) begin
      phase_nxt         = PH_START;
      high_pending_nxt  = 1'b0;
      pending_count_nxt = 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_START;
      high_pending_r  <= 1'b0;
      pending_count_r <= 8'd1;
    end else if (step) begin
      phase_r         <= phase_nxt;
      high_pending_r  <= high_pending_nxt;
      pending_count_r <= pending_count_nxt;
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import kdfd_pkg::*;

  localparam int HoldCycles = 300;
  localparam int SettleCycles = 4;
  localparam int CycleLimit = 200000;
  localparam int ItemsPerPhase = 230;
  localparam int NumPhases = 6;
  localparam logic [CfgIndexWidth-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    CHECK_MODEL,
    EXPECT_NOTHING,
    EXPECT_BEAT
  } row_check_t;

  typedef struct packed {
    logic [7:0] raw;
    logic       last;
    row_check_t check;
    result_t    beat;
  } stim_row_t;

  localparam result_t CutBeat = '{8'h00, 8'd0, 1'b1, 1'b1};

  localparam stim_row_t DirectedRows [27] = '{
    '{8'h41, 1'b0, EXPECT_BEAT, '{8'h41, 8'd1, 1'b0, 1'b0}},
    '{8'h00, 1'b1, EXPECT_BEAT, '{8'h00, 8'd1, 1'b0, 1'b1}},
    '{8'hFF, 1'b0, EXPECT_BEAT, '{8'hFF, 8'd1, 1'b0, 1'b0}},
    '{8'h23, 1'b0, EXPECT_NOTHING, '0},
    '{8'h41, 1'b0, EXPECT_BEAT, '{8'h01, 8'd1, 1'b0, 1'b0}},
    '{8'h23, 1'b0, EXPECT_NOTHING, '0},
    '{8'h7E, 1'b0, EXPECT_BEAT, '{8'h7E, 8'd1, 1'b0, 1'b0}},
    '{8'h26, 1'b0, CHECK_MODEL, '0},
    '{8'h23, 1'b0, CHECK_MODEL, '0},
    '{8'h26, 1'b1, CHECK_MODEL, '0},
    '{8'h7E, 1'b0, EXPECT_NOTHING, '0},
    '{8'h7E, 1'b0, EXPECT_NOTHING, '0},
    '{8'h26, 1'b0, CHECK_MODEL, '0},
    '{8'h7F, 1'b0, CHECK_MODEL, '0},
    '{8'h7E, 1'b0, EXPECT_NOTHING, '0},
    '{8'h20, 1'b0, EXPECT_NOTHING, '0},
    '{8'h5A, 1'b1, EXPECT_NOTHING, '0},
    '{8'h7E, 1'b0, EXPECT_NOTHING, '0},
    '{8'h1F, 1'b0, EXPECT_NOTHING, '0},
    '{8'h7E, 1'b0, CHECK_MODEL, '0},
    '{8'h26, 1'b0, EXPECT_NOTHING, '0},
    '{8'h26, 1'b0, CHECK_MODEL, '0},
    '{8'h7E, 1'b1, EXPECT_BEAT, CutBeat},
    '{8'h26, 1'b1, EXPECT_BEAT, CutBeat},
    '{8'h7E, 1'b0, EXPECT_NOTHING, '0},
    '{8'h25, 1'b1, EXPECT_BEAT, CutBeat},
    '{8'h23, 1'b1, EXPECT_BEAT, CutBeat}
  };

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [7:0]               cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [7:0]               in_byte = '0;
  logic                     in_last_in_field = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [7:0]               out_byte;
  logic [7:0]               out_repeat_count;
  logic                     out_truncated;
  logic                     out_field_end;

  kermit_data_field_decoder_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte          (in_byte),
    .in_last_in_field (in_last_in_field),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_repeat_count (out_repeat_count),
    .out_truncated    (out_truncated),
    .out_field_end    (out_field_end)
  );

  result_t     expected_chars[$];
  prefix_cfg_t shadow_prefixes;
  phase_t      seq_phase;
  logic        seq_high;
  logic [7:0]  seq_count;
  int          mismatches = 0;
  int          cycle_count = 0;
  int          send_idle_pct = 19;
  int          recv_idle_pct = 70;
  int          phase_items = 0;
  int          hold_left = 0;
  logic        hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CycleLimit) @(posedge clk);
    $display("[kermit_data_field_decoder_top] ERROR");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = HoldCycles;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_beats
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got byte %0d count %0d", $time,
                 out_byte, out_repeat_count);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        compare_field("out_byte", want.out_byte, out_byte);
        compare_field("out_repeat_count", want.repeat_count, out_repeat_count);
        compare_field("out_truncated", 8'(want.truncated), 8'(out_truncated));
        compare_field("out_field_end", 8'(want.field_end), 8'(out_field_end));
      end
    end
  end

  function automatic void restart_sequence();
    seq_phase = PH_START;
    seq_high = 1'b0;
    seq_count = 8'd1;
  endfunction

  function automatic logic decode_field_byte(input logic [7:0] b, input logic last,
                                             output result_t beat);
    logic       have_char;
    logic [7:0] ch;
    logic [7:0] cnt;
    have_char = 1'b0;
    ch = '0;
    beat = '0;
    case (seq_phase)
      PH_QUOTED: begin
        if (b == shadow_prefixes.control_prefix || b == shadow_prefixes.highbit_prefix ||
            b == shadow_prefixes.repeat_prefix) begin
          ch = b;
        end else begin
          ch = b ^ QuoteFlip;
        end
        have_char = 1'b1;
      end
      PH_COUNT: begin
        seq_count = b - CountBias;
        seq_phase = PH_AFTER_CNT;
      end
      default: begin
        if (seq_phase == PH_START && b == shadow_prefixes.repeat_prefix) begin
          seq_phase = PH_COUNT;
        end else if (seq_phase != PH_AFTER_HIGH && b == shadow_prefixes.highbit_prefix) begin
          seq_high = 1'b1;
          seq_phase = PH_AFTER_HIGH;
        end else if (b == shadow_prefixes.control_prefix) begin
          seq_phase = PH_QUOTED;
        end else begin
          ch = b;
          have_char = 1'b1;
        end
      end
    endcase
    if (have_char) begin
      cnt = seq_count;
      beat.out_byte = seq_high ? (ch | HighBit) : ch;
      beat.repeat_count = cnt;
      beat.field_end = last;
      restart_sequence();
      return cnt != 8'd0;
    end
    if (last) begin
      restart_sequence();
      beat = CutBeat;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_beat(input logic [7:0] b, input logic last, input row_check_t check,
                           input result_t typed);
    result_t predicted;
    logic    produced;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_in_field <= last;
    do @(posedge clk); while (!in_ready);
    produced = decode_field_byte(b, last, predicted);
    case (check)
      EXPECT_BEAT: expected_chars.push_back(typed);
      EXPECT_NOTHING: ;
      default: if (produced) expected_chars.push_back(predicted);
    endcase
    phase_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic program_prefixes(input logic [7:0] c, input logic [7:0] h,
                                  input logic [7:0] r);
    wait_drained();
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CONTROL_PREFIX;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_index <= CFG_HIGHBIT_PREFIX;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_index <= CFG_REPEAT_PREFIX;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_wdata <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_prefixes = '{c, h, r};
    @(posedge clk);
  endtask

  task automatic send_field();
    logic [7:0] seq[$];
    int         n_chars;
    int         mark;
    logic       cut;
    n_chars = $urandom_range(1, 6);
    cut = ($urandom_range(99) < 12);
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 6)) seq.push_back(8'($urandom_range(255)));
    end else begin
      for (int i = 0; i < n_chars; i++) begin
        mark = seq.size();
        if ($urandom_range(99) < 30) begin
          seq.push_back(shadow_prefixes.repeat_prefix);
          case ($urandom_range(4))
            0: seq.push_back(CountBias);
            1: seq.push_back(CountBias + 8'd1);
            2: seq.push_back(CountBias - 8'd1);
            default: seq.push_back(8'($urandom_range(255)));
          endcase
        end
        if ($urandom_range(99) < 30) seq.push_back(shadow_prefixes.highbit_prefix);
        if (cut && i == n_chars - 1) begin
          if (seq.size() == mark || $urandom_range(1)) begin
            seq.push_back(shadow_prefixes.control_prefix);
          end
        end else if ($urandom_range(99) < 35) begin
          seq.push_back(shadow_prefixes.control_prefix);
          case ($urandom_range(9))
            0: seq.push_back(shadow_prefixes.control_prefix);
            1: seq.push_back(shadow_prefixes.highbit_prefix);
            2: seq.push_back(shadow_prefixes.repeat_prefix);
            default: seq.push_back(8'($urandom_range(255)));
          endcase
        end else begin
          seq.push_back(8'($urandom_range(255)));
        end
      end
    end
    foreach (seq[i]) send_beat(seq[i], i == seq.size() - 1, CHECK_MODEL, '0);
  endtask

  initial begin
    logic hold_done;
    logic pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    shadow_prefixes = '{ControlPrefixReset, HighbitPrefixReset, RepeatPrefixReset};
    restart_sequence();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedRows[i]) begin
      send_beat(DirectedRows[i].raw, DirectedRows[i].last, DirectedRows[i].check,
                DirectedRows[i].beat);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: program_prefixes(ControlPrefixReset, HighbitPrefixReset, RepeatPrefixReset);
        1: program_prefixes(8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)));
        2: program_prefixes(8'h00, 8'hFF, 8'h7F);
        3: program_prefixes(8'hFF, 8'h00, 8'h00);
        4: program_prefixes(8'h41, 8'h41, 8'h41);
        default: program_prefixes(8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255)));
      endcase
      send_idle_pct = (ph < 2) ? 19 : (ph < 4) ? 70 : 0;
      recv_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 19 : 0;
      phase_items = 0;
      while (phase_items < ItemsPerPhase) begin
        if (ph == 4 && !hold_done && phase_items > 40) begin
          hold_req = 1'b1;
          hold_done = 1'b1;
        end
        if (ph == 2 && !pause_done && phase_items > 100) begin
          wait_drained();
          pause_done = 1'b1;
        end
        send_field();
      end
    end

    wait_drained();
    repeat (SettleCycles * 2) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("[kermit_data_field_decoder_top] OK");
    end else begin
      $display("[kermit_data_field_decoder_top] ERROR");
    end
    $finish;
  end

endmodule
